/* rtl/rrfp_pkg.sv */
// report frame parser package: frame layout, header and footer patterns, status codes
// and the structs passed between the front end, the command queue and the gate drain
// no dependencies
package rrfp_pkg;

  localparam int unsigned GATE_COUNT = 16;

  localparam int unsigned POS_W       = 6;
  localparam int unsigned GATES_AT_N  = 9;
  localparam int unsigned FOOTER_AT_N = GATES_AT_N + 2 * GATE_COUNT;
  localparam int unsigned FRAME_LEN_N = FOOTER_AT_N + 4;

  localparam logic [POS_W-1:0] HDR_LEN    = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(5);
  localparam logic [POS_W-1:0] POS_PRES   = POS_W'(6);
  localparam logic [POS_W-1:0] POS_DIST_LO = POS_W'(7);
  localparam logic [POS_W-1:0] POS_DIST_HI = POS_W'(8);
  localparam logic [POS_W-1:0] GATES_AT   = POS_W'(GATES_AT_N);
  localparam logic [POS_W-1:0] FOOTER_AT  = POS_W'(FOOTER_AT_N);
  localparam logic [POS_W-1:0] FRAME_LEN  = POS_W'(FRAME_LEN_N);
  localparam logic [POS_W-1:0] FTR_STORED_END = POS_W'(FRAME_LEN_N - 1);
  localparam logic [POS_W-1:0] BAD_LEN_AT = POS_W'(11);

  localparam logic [15:0] PAYLOAD_LEN = 16'(3 + 2 * GATE_COUNT);
  localparam logic [7:0]  PRESENT_CODE = 8'h01;
  localparam logic [3:0]  GATE_LAST = 4'(GATE_COUNT - 1);

  localparam logic [7:0] HDR_PAT [4] = '{8'hF4, 8'hF3, 8'hF2, 8'hF1};
  localparam logic [7:0] FTR_PAT [4] = '{8'hF8, 8'hF7, 8'hF6, 8'hF5};

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_FTR = 2'd2
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  presence;
    logic [15:0] distance;
    logic        bank;
  } cmd_t;

  typedef struct packed {
    logic       en;
    logic       bank;
    logic [3:0] gate;
    logic       hi;
    logic [7:0] data;
  } gwr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

endpackage

/* rtl/rrfp_in_if.sv */
// byte channel into the report frame parser: valid, ready and one received byte per beat
// no dependencies
interface rrfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/rrfp_out_if.sv */
// result channel out of the report frame parser: valid, ready and one gate or status beat
// no dependencies
interface rrfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  presence_code;
  logic        presence_detected;
  logic [15:0] target_distance;
  logic [3:0]  gate_index;
  logic [15:0] gate_energy;
  logic        last;

  modport source (output valid, output status, output presence_code,
                  output presence_detected, output target_distance, output gate_index,
                  output gate_energy, output last, input ready);
  modport sink (input valid, input status, input presence_code, input presence_detected,
                input target_distance, input gate_index, input gate_energy, input last,
                output ready);
endinterface

/* rtl/rrfp_front.sv */
// byte front end: header hunt, length and payload capture, footer check, command push
// depends on rrfp_pkg and rrfp_in_if
module rrfp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  rrfp_in_if.sink           rx_i,
  input  logic              q_full_i,
  input  rrfp_pkg::rel_t    rel_i,
  output logic              push_o,
  output rrfp_pkg::cmd_t    cmd_o,
  output rrfp_pkg::gwr_t    gwr_o
);
  import rrfp_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] gate_off;
  logic [POS_W-1:0] ftr_off;
  logic [15:0]      len_q;
  logic [7:0]       pres_q;
  logic [15:0]      dist_q;
  logic [7:0]       ftr_q [3];
  logic [1:0]       busy_q;
  logic             wb_q;
  logic             accept;
  logic             ftr_ok;
  logic             in_body;

  assign rx_i.ready = !q_full_i && !busy_q[wb_q];
  assign accept     = rx_i.valid && rx_i.ready;
  assign pos_inc    = pos_q + POS_W'(1);
  assign gate_off   = pos_q - GATES_AT;
  assign ftr_off    = pos_q - FOOTER_AT;
  assign in_body    = (pos_q >= HDR_LEN) && (pos_q < FRAME_LEN);
  assign ftr_ok     = (ftr_q[0] == FTR_PAT[0]) && (ftr_q[1] == FTR_PAT[1]) &&
                      (ftr_q[2] == FTR_PAT[2]) && (rx_i.rx_byte == FTR_PAT[3]);

  always_comb begin
    pos_d          = pos_q;
    push_o         = 1'b0;
    cmd_o.status   = ST_GOOD;
    cmd_o.presence = pres_q;
    cmd_o.distance = dist_q;
    cmd_o.bank     = wb_q;
    gwr_o.en       = 1'b0;
    gwr_o.bank     = wb_q;
    gwr_o.gate     = gate_off[4:1];
    gwr_o.hi       = gate_off[0];
    gwr_o.data     = rx_i.rx_byte;
    if (accept) begin
      if (pos_q < HDR_LEN) begin
        if (rx_i.rx_byte == HDR_PAT[pos_q[1:0]]) begin
          pos_d = pos_inc;
        end else if (rx_i.rx_byte == HDR_PAT[0]) begin
          pos_d = POS_W'(1);
        end else begin
          pos_d = '0;
        end
      end else if (pos_q >= FRAME_LEN) begin
        pos_d = '0;
      end else begin
        pos_d    = pos_inc;
        gwr_o.en = (pos_q >= GATES_AT) && (pos_q < FOOTER_AT);
        if (len_q != PAYLOAD_LEN) begin
          if (pos_inc >= BAD_LEN_AT) begin
            pos_d        = '0;
            push_o       = 1'b1;
            cmd_o.status = ST_BAD_LEN;
          end
        end else if (pos_inc == FRAME_LEN) begin
          pos_d        = '0;
          push_o       = 1'b1;
          cmd_o.status = ftr_ok ? ST_GOOD : ST_BAD_FTR;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      busy_q <= '0;
      wb_q   <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (accept && pos_q == POS_LEN_LO) begin
        len_q[7:0] <= rx_i.rx_byte;
      end
      if (accept && pos_q == POS_LEN_HI) begin
        len_q[15:8] <= rx_i.rx_byte;
      end
      if (rel_i.en) begin
        busy_q[rel_i.bank] <= 1'b0;
      end
      if (push_o && cmd_o.status == ST_GOOD) begin
        busy_q[wb_q] <= 1'b1;
        wb_q         <= !wb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_body) begin
      if (pos_q == POS_PRES) begin
        pres_q <= rx_i.rx_byte;
      end
      if (pos_q == POS_DIST_LO) begin
        dist_q[7:0] <= rx_i.rx_byte;
      end
      if (pos_q == POS_DIST_HI) begin
        dist_q[15:8] <= rx_i.rx_byte;
      end
      if (pos_q >= FOOTER_AT && pos_q < FTR_STORED_END) begin
        ftr_q[ftr_off[1:0]] <= rx_i.rx_byte;
      end
    end
  end

  a_gate_bank_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gwr_o.en |-> !busy_q[gwr_o.bank])
    else $error("gate write into a bank still draining");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i)
    else $error("command pushed into a full queue");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < FRAME_LEN)
    else $error("frame position past the end of the frame");

endmodule

/* rtl/rrfp_queue.sv */
// two-entry command queue between the byte front end and the gate drain
// depends on rrfp_pkg
module rrfp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rrfp_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output rrfp_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);
  import rrfp_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q;
  logic [QPTR_W-1:0] rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

/* rtl/rrfp_back.sv */
// gate drain: two-bank gate energy store and the output register that sends one beat
// per gate of a good frame, or one status beat
// depends on rrfp_pkg and rrfp_out_if
module rrfp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rrfp_pkg::gwr_t gwr_i,
  input  rrfp_pkg::cmd_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  output rrfp_pkg::rel_t rel_o,
  rrfp_out_if.source     res_o
);
  import rrfp_pkg::*;

  logic [7:0]  lo_q [2][16];
  logic [7:0]  hi_q [2][16];
  logic [3:0]  idx_q;
  logic        ov_q;
  logic        load;
  logic        good;
  logic        last_beat;
  logic [1:0]  status_q;
  logic [7:0]  pres_q;
  logic        det_q;
  logic [15:0] dist_q;
  logic [3:0]  gidx_q;
  logic [15:0] energy_q;
  logic        last_q;

  assign good      = (head_i.status == ST_GOOD);
  assign last_beat = !good || (idx_q == GATE_LAST);
  assign load      = !empty_i && (!ov_q || res_o.ready);
  assign pop_o     = load && last_beat;
  assign rel_o.en   = pop_o && good;
  assign rel_o.bank = head_i.bank;

  assign res_o.valid             = ov_q;
  assign res_o.status            = status_q;
  assign res_o.presence_code     = pres_q;
  assign res_o.presence_detected = det_q;
  assign res_o.target_distance   = dist_q;
  assign res_o.gate_index        = gidx_q;
  assign res_o.gate_energy       = energy_q;
  assign res_o.last              = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        idx_q <= last_beat ? 4'd0 : idx_q + 4'd1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (gwr_i.en) begin
      if (gwr_i.hi) begin
        hi_q[gwr_i.bank][gwr_i.gate] <= gwr_i.data;
      end else begin
        lo_q[gwr_i.bank][gwr_i.gate] <= gwr_i.data;
      end
    end
    if (load) begin
      status_q <= head_i.status;
      last_q   <= last_beat;
      if (good) begin
        pres_q   <= head_i.presence;
        det_q    <= (head_i.presence == PRESENT_CODE);
        dist_q   <= head_i.distance;
        gidx_q   <= idx_q;
        energy_q <= {hi_q[head_i.bank][idx_q], lo_q[head_i.bank][idx_q]};
      end else begin
        pres_q   <= '0;
        det_q    <= 1'b0;
        dist_q   <= '0;
        gidx_q   <= '0;
        energy_q <= '0;
      end
    end
  end

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && status_q != ST_GOOD) |-> last_q)
    else $error("status beat not marked last");

  a_gate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (gidx_q <= GATE_LAST))
    else $error("gate index beyond gate count");

  a_burst_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && res_o.ready && !last_q) |=> ov_q)
    else $error("gap inside a gate burst");

endmodule

/* rtl/radar_report_frame_parser_top.sv */
// report frame parser top level: front end, command queue and gate drain
// one byte per cycle unless stalled; results pass the queue, then the output register
// a good frame drains GATE_COUNT beats, one per cycle while ready; a status, one beat
// input stalls only while both queue slots or the next gate bank are still draining
// async active-low reset clears position, length, queue, bank busy flags, output valid
// depends on rrfp_pkg, rrfp_in_if, rrfp_out_if, rrfp_front, rrfp_queue, rrfp_back
module radar_report_frame_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  rrfp_in_if.sink     rx_i,
  rrfp_out_if.source  res_o
);
  import rrfp_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cmd_t cmd;
  cmd_t head;
  gwr_t gwr;
  rel_t rel;

  rrfp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx_i     (rx_i),
    .q_full_i (q_full),
    .rel_i    (rel),
    .push_o   (push),
    .cmd_o    (cmd),
    .gwr_o    (gwr)
  );

  rrfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rrfp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .gwr_i   (gwr),
    .head_i  (head),
    .empty_i (q_empty),
    .pop_o   (pop),
    .rel_o   (rel),
    .res_o   (res_o)
  );

endmodule
